FILE: rtl/core/tntd_pkg.sv
// ----------------------------------------------------------------------------
// tntd_pkg
// Shared types and constants for the tiled nibble texture decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tntd_pkg;

    // configuration register width and index width
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // output field widths
    localparam int ADDR_W = 21;
    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;

    // tile geometry
    localparam int TILE_W_LOG2  = 3;   // 8 texels across every tile
    localparam int MIN_WIDTH    = 8;

    // output word: byte_address, first_byte, second_byte, padded to bytes
    localparam int M_DATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_I4  = 2'd0,
        MODE_IA4 = 2'd1,
        MODE_C4  = 2'd2
    } mode_t;

    typedef struct packed {
        logic ia;    // 8x4 tiles, two bytes per texel
        logic raw;   // nibbles kept as indices
    } mode_flags_t;

    // repeat a nibble into both halves of a byte
    function automatic logic [BYTE_W-1:0] widen(input logic [NIB_W-1:0] n);
        widen = {n, n};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tntd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tntd_cfg_regs
// Mode, pitch and height registers, with clamping and tile count decode.
// ----------------------------------------------------------------------------
`default_nettype none

module tntd_cfg_regs import tntd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_W      = 7,
    parameter int ROW_W      = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output      logic                 cfg_clear,
    output      mode_flags_t          flags,
    output      logic [CFG_W-1:0]     pitch,
    output      logic [COL_W:0]       cols,
    output      logic [ROW_W:0]       rows
);

    localparam logic [CFG_W+1:0] MAX_W_EXT = (CFG_W+2)'(MAX_WIDTH);
    localparam logic [CFG_W+1:0] MAX_H_EXT = (CFG_W+2)'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] MIN_W     = CFG_W'(MIN_WIDTH);

    logic [1:0]       mode_reg, mode_next;
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [CFG_W+1:0] h_sum;
    logic [CFG_W+1:0] w_sum;

    // values are stored already clamped
    always_comb begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        cfg_clear   = 1'b0;
        if (cfg_valid) begin
            case (cfg_index)
                REG_MODE: begin
                    mode_next = cfg_data[1:0];
                    cfg_clear = 1'b1;
                end
                REG_WIDTH: begin
                    cfg_clear = 1'b1;
                    if (cfg_data < MIN_W)
                        width_next = MIN_W;
                    else if ({2'b00, cfg_data} > MAX_W_EXT)
                        width_next = CFG_W'(MAX_WIDTH);
                    else
                        width_next = cfg_data;
                end
                REG_HEIGHT: begin
                    cfg_clear = 1'b1;
                    if (cfg_data == '0)
                        height_next = CFG_W'(1);
                    else if ({2'b00, cfg_data} > MAX_H_EXT)
                        height_next = CFG_W'(MAX_HEIGHT);
                    else
                        height_next = cfg_data;
                end
                default: begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_I4;
            width_reg  <= CFG_W'(8);
            height_reg <= CFG_W'(8);
        end else begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // mode 3 falls back to I4 decoding
    assign flags.ia  = (mode_reg == MODE_IA4);
    assign flags.raw = (mode_reg == MODE_C4);
    assign pitch     = width_reg;

    assign w_sum = {2'b00, width_reg} + (CFG_W+2)'(7);
    assign h_sum = flags.ia ? ({2'b00, height_reg} + (CFG_W+2)'(3))
                            : ({2'b00, height_reg} + (CFG_W+2)'(7));

    assign cols = w_sum[TILE_W_LOG2 +: (COL_W+1)];
    assign rows = flags.ia ? h_sum[2 +: (ROW_W+1)] : h_sum[3 +: (ROW_W+1)];

endmodule

`default_nettype wire

FILE: rtl/core/tntd_tile_counter.sv
// ----------------------------------------------------------------------------
// tntd_tile_counter
// Tile position counters and the input register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tntd_tile_counter import tntd_pkg::*; #(
    parameter int COL_W  = 7,
    parameter int ROW_W  = 8,
    parameter int LINE_W = 12,
    parameter int XOFF_W = 11
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              clear,
    input  wire mode_flags_t       flags,
    input  wire logic [COL_W:0]    cols,
    input  wire logic [ROW_W:0]    rows,
    input  wire logic [BYTE_W-1:0] src_byte,
    output      logic [BYTE_W-1:0] byte_q,
    output      logic [LINE_W-1:0] line_q,
    output      logic [XOFF_W-1:0] xoff_q,
    output      logic              end_q
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [2:0]       rit_reg, rit_next;
    logic [2:0]       bir_reg, bir_next;

    logic [BYTE_W-1:0] byte_reg;
    logic [LINE_W-1:0] line_reg;
    logic [XOFF_W-1:0] xoff_reg;
    logic              end_reg;

    logic              last_byte, last_line, last_col, last_row, img_end;
    logic [3:0]        bir_inc, rit_inc, sub_x;
    logic [LINE_W-1:0] line_now;
    logic [XOFF_W-1:0] xoff_now;

    assign bir_inc = {1'b0, bir_reg} + 4'd1;
    assign rit_inc = {1'b0, rit_reg} + 4'd1;

    assign last_byte = flags.ia ? (bir_inc >= 4'd8) : (bir_inc >= 4'd4);
    assign last_line = flags.ia ? (rit_inc >= 4'd4) : (rit_inc >= 4'd8);
    assign last_col  = (({1'b0, col_reg} + (COL_W+1)'(1)) >= cols);
    assign last_row  = (({1'b0, row_reg} + (ROW_W+1)'(1)) >= rows);
    assign img_end   = last_byte && last_line && last_col && last_row;

    // line = tile_row * tile height + row in tile
    assign line_now = flags.ia
        ? ((LINE_W'(row_reg) << 2) + LINE_W'(rit_reg))
        : ((LINE_W'(row_reg) << 3) + LINE_W'(rit_reg));
    // byte offset inside the tile row, two texels per byte outside IA4
    assign sub_x    = flags.ia ? {1'b0, bir_reg} : {bir_reg, 1'b0};
    assign xoff_now = (XOFF_W'(col_reg) << TILE_W_LOG2) + XOFF_W'(sub_x);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        rit_next = rit_reg;
        bir_next = bir_reg;
        if (clear) begin
            col_next = '0;
            row_next = '0;
            rit_next = '0;
            bir_next = '0;
        end else if (step) begin
            if (!last_byte) begin
                bir_next = bir_inc[2:0];
            end else begin
                bir_next = '0;
                if (!last_line) begin
                    rit_next = rit_inc[2:0];
                end else begin
                    rit_next = '0;
                    if (!last_col) begin
                        col_next = col_reg + COL_W'(1);
                    end else begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + ROW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            rit_reg <= '0;
            bir_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            rit_reg <= rit_next;
            bir_reg <= bir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            byte_reg <= src_byte;
            line_reg <= line_now;
            xoff_reg <= xoff_now;
            end_reg  <= img_end;
        end
    end

    assign byte_q = byte_reg;
    assign line_q = line_reg;
    assign xoff_q = xoff_reg;
    assign end_q  = end_reg;

    // a register write starts a new image
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> (col_reg == '0 && row_reg == '0 && rit_reg == '0 && bir_reg == '0))
        else $error("counters not cleared after register write");

    // the last byte of the image wraps all counters
    a_end_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && img_end && !clear) |=>
            (col_reg == '0 && row_reg == '0 && rit_reg == '0 && bir_reg == '0))
        else $error("counters did not wrap at image end");

    // outside IA4 a tile row holds four bytes
    a_bir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (!flags.ia && !$past(clear)) |-> (bir_reg[2] == 1'b0))
        else $error("byte_in_row out of range");

endmodule

`default_nettype wire

FILE: rtl/core/tntd_pixel_stage.sv
// ----------------------------------------------------------------------------
// tntd_pixel_stage
// Linear address and nibble widening (zero extension in C4), into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tntd_pixel_stage import tntd_pkg::*; #(
    parameter int LINE_W = 12,
    parameter int XOFF_W = 11
) (
    input  wire logic              aclk,
    input  wire logic              load,
    input  wire mode_flags_t       flags,
    input  wire logic [CFG_W-1:0]  pitch,
    input  wire logic [BYTE_W-1:0] byte_q,
    input  wire logic [LINE_W-1:0] line_q,
    input  wire logic [XOFF_W-1:0] xoff_q,
    input  wire logic              end_q,
    output      logic [ADDR_W-1:0] byte_address,
    output      logic [BYTE_W-1:0] first_byte,
    output      logic [BYTE_W-1:0] second_byte,
    output      logic              image_end
);

    localparam int SUM_W  = LINE_W + CFG_W + 2;
    localparam int CALC_W = (SUM_W > ADDR_W) ? SUM_W : ADDR_W;

    logic [CALC_W-1:0] prod, sum, addr_full;
    logic [BYTE_W-1:0] hi_b, lo_b;

    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] first_reg, second_reg;
    logic              end_reg;

    assign prod      = CALC_W'(line_q) * CALC_W'(pitch);
    assign sum       = prod + CALC_W'(xoff_q);
    assign addr_full = flags.ia ? (sum << 1) : sum;

    assign hi_b = flags.raw ? {4'h0, byte_q[7:4]} : widen(byte_q[7:4]);
    assign lo_b = flags.raw ? {4'h0, byte_q[3:0]} : widen(byte_q[3:0]);

    always_ff @(posedge aclk) begin
        if (load) begin
            addr_reg   <= addr_full[ADDR_W-1:0];
            first_reg  <= hi_b;
            second_reg <= lo_b;
            end_reg    <= end_q;
        end
    end

    assign byte_address = addr_reg;
    assign first_byte   = first_reg;
    assign second_byte  = second_reg;
    assign image_end    = end_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tiled_nibble_texture_decode_top.sv
// ----------------------------------------------------------------------------
// tiled_nibble_texture_decode_top
// Detiles a 4-bit texture (I4, IA4, C4) one source byte per word.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one tiled source byte per word, in memory order.
//   m_ channel: byte pair for the linear image; tdata holds the address of
//   the first byte and both bytes, tlast marks the last byte of the image.
//   cfg channel: register writes (0 mode, 1 width, 2 height), always ready.
//   Any write to a listed register restarts the image at the first tile.
//   Write the registers only while nothing is in flight.
// Timing
//   Two registers: input register (counters, line, tile offset), then
//   result register (line * pitch multiply, add, nibble widening).
//   Throughput one word per cycle while m_tready stays high; the multiply sets the clock.
// Reset
//   Both stages empty, I4 mode, 8 x 8 image, counters at the first tile.
// Stall
//   When m_tready is low the result holds; the input stage still takes one
//   more word if it is empty, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_nibble_texture_decode_top import tntd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input words
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [7:0]           s_tdata,    // [7:0] source_byte
    // result words
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [M_DATA_W-1:0]  m_tdata,    // [20:0] byte_address,
                                                  // [28:21] first_byte,
                                                  // [36:29] second_byte, zero pad
    output      logic                 m_tlast,    // image_end
    // register writes
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // counter widths follow the largest image
    localparam int COLS_MAX = (MAX_WIDTH + 7) / 8;
    localparam int ROWS_MAX = (MAX_HEIGHT + 3) / 4;
    localparam int COL_W    = (COLS_MAX > 2) ? $clog2(COLS_MAX) : 1;
    localparam int ROW_W    = (ROWS_MAX > 2) ? $clog2(ROWS_MAX) : 1;
    localparam int LINE_W   = ROW_W + 4;
    localparam int XOFF_W   = COL_W + TILE_W_LOG2 + 1;

    logic              st_valid_reg, st_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic              advance, accept;

    logic              cfg_clear;
    mode_flags_t       flags;
    logic [CFG_W-1:0]  pitch;
    logic [COL_W:0]    cols;
    logic [ROW_W:0]    rows;

    logic [BYTE_W-1:0] byte_q;
    logic [LINE_W-1:0] line_q;
    logic [XOFF_W-1:0] xoff_q;
    logic              end_q;

    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] first_byte, second_byte;
    logic              image_end;

    // --- handshake -------------------------------------------------------
    // result register moves when empty or taken; input stage moves with it
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !st_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (accept)
            st_valid_next = 1'b1;
        else if (advance)
            st_valid_next = 1'b0;
        m_valid_next = advance ? st_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign cfg_ready = 1'b1;

    // --- configuration ---------------------------------------------------
    tntd_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_clear (cfg_clear),
        .flags     (flags),
        .pitch     (pitch),
        .cols      (cols),
        .rows      (rows)
    );

    // --- stage 1: tile position --------------------------------------------
    tntd_tile_counter #(
        .COL_W  (COL_W),
        .ROW_W  (ROW_W),
        .LINE_W (LINE_W),
        .XOFF_W (XOFF_W)
    ) u_cnt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .clear    (cfg_clear),
        .flags    (flags),
        .cols     (cols),
        .rows     (rows),
        .src_byte (s_tdata),
        .byte_q   (byte_q),
        .line_q   (line_q),
        .xoff_q   (xoff_q),
        .end_q    (end_q)
    );

    // --- stage 2: address and texel bytes ------------------------------------
    tntd_pixel_stage #(
        .LINE_W (LINE_W),
        .XOFF_W (XOFF_W)
    ) u_pix (
        .aclk         (aclk),
        .load         (advance && st_valid_reg),
        .flags        (flags),
        .pitch        (pitch),
        .byte_q       (byte_q),
        .line_q       (line_q),
        .xoff_q       (xoff_q),
        .end_q        (end_q),
        .byte_address (byte_address),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .image_end    (image_end)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, second_byte, first_byte, byte_address};
    assign m_tlast  = image_end;

    // input only blocks behind a full, stalled pipe
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready && st_valid_reg))
        else $error("input stalled with room in the pipe");

    // a word in stage 1 reaches the result register on the next advance
    a_stage_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && advance) |=> m_valid_reg)
        else $error("stage 1 word lost");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(byte_address)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: dv/tntd_pair_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tntd_pair_checker
// Watches the source, result and register channels of the texture decoder,
// works out every byte pair the block should write, and checks each result
// word against the oldest pair still owed.
// ----------------------------------------------------------------------------

module tntd_pair_checker import tntd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatch_count,
    output int                   pairs_pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] hi_byte;
        logic [BYTE_W-1:0] lo_byte;
        logic              end_flag;
    } byte_pair_t;

    logic [1:0]       mode_q;
    logic [CFG_W-1:0] width_q;
    logic [CFG_W-1:0] height_q;

    logic [6:0] tile_col;
    logic [7:0] tile_row;
    logic [2:0] tex_row;
    logic [2:0] row_byte;

    byte_pair_t expected_pairs[$];
    int         errors = 0;

    function automatic void clear_position();
        tile_col = '0;
        tile_row = '0;
        tex_row  = '0;
        row_byte = '0;
    endfunction

    // pair for one source byte, then step the tile walk
    function automatic byte_pair_t detile_byte(input logic [7:0] src);
        int         w, h, tile_h, row_bytes, cols, rows, line, addr;
        bit         ia, raw, last_byte, last_line, last_col, last_row;
        byte_pair_t p;
        ia        = (mode_q == MODE_IA4);
        raw       = (mode_q == MODE_C4);
        tile_h    = ia ? 4 : 8;
        row_bytes = ia ? 8 : 4;
        w = int'(width_q);
        h = int'(height_q);
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        cols = (w + 7) / 8;
        rows = (h + tile_h - 1) / tile_h;

        line = int'(tile_row) * tile_h + int'(tex_row);
        if (ia)
            addr = (line * w + int'(tile_col) * 8 + int'(row_byte)) * 2;
        else
            addr = line * w + int'(tile_col) * 8 + int'(row_byte) * 2;

        p.addr    = addr[ADDR_W-1:0];
        p.hi_byte = raw ? {4'h0, src[7:4]} : {src[7:4], src[7:4]};
        p.lo_byte = raw ? {4'h0, src[3:0]} : {src[3:0], src[3:0]};

        last_byte  = (int'(row_byte) + 1 >= row_bytes);
        last_line  = (int'(tex_row) + 1 >= tile_h);
        last_col   = (int'(tile_col) + 1 >= cols);
        last_row   = (int'(tile_row) + 1 >= rows);
        p.end_flag = last_byte && last_line && last_col && last_row;

        if (!last_byte) begin
            row_byte = row_byte + 3'd1;
        end else begin
            row_byte = '0;
            if (!last_line) begin
                tex_row = tex_row + 3'd1;
            end else begin
                tex_row = '0;
                if (!last_col) begin
                    tile_col = tile_col + 7'd1;
                end else begin
                    tile_col = '0;
                    tile_row = last_row ? 8'd0 : tile_row + 8'd1;
                end
            end
        end
        return p;
    endfunction

    always @(posedge aclk) begin : track
        byte_pair_t exp_pair;
        byte_pair_t got_pair;
        if (!aresetn) begin
            mode_q   = MODE_I4;
            width_q  = CFG_W'(8);
            height_q = CFG_W'(8);
            clear_position();
            expected_pairs.delete();
        end else begin
            // results first, so a pair can never meet its own source word
            if (m_tvalid && m_tready) begin
                got_pair.addr     = m_tdata[ADDR_W-1:0];
                got_pair.hi_byte  = m_tdata[ADDR_W +: BYTE_W];
                got_pair.lo_byte  = m_tdata[ADDR_W+BYTE_W +: BYTE_W];
                got_pair.end_flag = m_tlast;
                if (expected_pairs.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: result word with none owed:",
                                  " addr %0d bytes %02h %02h end %0b"},
                                 $time, got_pair.addr, got_pair.hi_byte, got_pair.lo_byte,
                                 got_pair.end_flag);
                end else begin
                    exp_pair = expected_pairs.pop_front();
                    if (got_pair !== exp_pair) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch: expected addr %0d bytes %02h %02h end %0b,",
                                      " got addr %0d bytes %02h %02h end %0b"},
                                     $time, exp_pair.addr, exp_pair.hi_byte, exp_pair.lo_byte,
                                     exp_pair.end_flag, got_pair.addr, got_pair.hi_byte,
                                     got_pair.lo_byte, got_pair.end_flag);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE: begin
                        mode_q = cfg_data[1:0];
                        clear_position();
                    end
                    REG_WIDTH: begin
                        width_q = cfg_data;
                        clear_position();
                    end
                    REG_HEIGHT: begin
                        height_q = cfg_data;
                        clear_position();
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_pairs.push_back(detile_byte(s_tdata));
        end
        mismatch_count <= errors;
        pairs_pending  <= expected_pairs.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tiled nibble texture decoder: a few hand-picked
// source words on the reset image, then a string of images under varied modes
// and sizes (clamped and unused values included) with random bytes, bursty
// input and a stalling receiver. A separate checker predicts every word.
// ----------------------------------------------------------------------------

module tb import tntd_pkg::*;;

    // register index and mode code with no function in the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
    localparam logic [1:0]           MODE_UNUSED = 2'd3;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving anywhere
    localparam int LONG_HOLD    = 300;   // receiver hold-off, cycles
    localparam int HOLD_AT      = 400;   // source words sent before the hold-off
    localparam int RANDOM_WORDS = 1700;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;    // [7:0] source_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;           // [20:0] addr, [28:21] first, [36:29] second
    logic                 m_tlast;           // image_end
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int mismatch_count;
    int pairs_pending;
    int words_sent = 0;
    int burst_left = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    tiled_nibble_texture_decode_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tntd_pair_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pairs_pending  (pairs_pending)
    );

    // One source word. Bursts of random length, random gaps between them;
    // tvalid stays high inside a burst, never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        words_sent++;
    endtask

    // pending count is registered behind the handshake, so always wait on the clock first
    task automatic wait_drained();
        do @(posedge aclk); while (pairs_pending != 0);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    // New image setting, then n random source words. With poke set, the
    // spare register is written half way through, which must not restart
    // the image.
    task automatic run_image(input logic [1:0] mode, input int w, input int h,
                             input int n, input bit poke);
        wait_drained();
        write_reg(REG_MODE, int'(mode));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_valid <= 1'b0;
        for (int i = 0; i < n; i++) begin
            if (poke && i == n / 2) begin
                s_tvalid <= 1'b0;
                burst_left = 0;
                wait_drained();
                write_reg(REG_SPARE, $urandom_range(0, 2047));
                cfg_valid <= 1'b0;
            end
            send_byte(8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Receiver: switches at random among four stall styles. Once, after enough
    // source words, it holds off long enough for the block to back up.
    initial begin : receiver
        int  cyc;
        int  style;
        bit  held;
        cyc   = 0;
        style = 0;
        held  = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && words_sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (cyc % 64 == 0) style = $urandom_range(0, 3);
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= (cyc % 3 != 0);
                endcase
                cyc++;
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("tiled_nibble_texture_decode_top verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] corner[$];
        logic [1:0] mode;
        int         w, h;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset image (I4, 8 x 8): nibble extremes and walking bits
        corner = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h5A, 8'hA5};
        for (int k = 0; k < 8; k++) corner.push_back(8'h01 << k);
        for (int k = 0; k < 8; k++) corner.push_back(~(8'h01 << k));
        foreach (corner[k]) send_byte(corner[k]);
        s_tvalid <= 1'b0;
        burst_left = 0;

        // Settings chosen by hand: every mode, size extremes, clamped sizes
        run_image(MODE_C4,     8,    8,    64,  1'b0);  // two whole images, wrap
        run_image(MODE_IA4,    8,    4,    64,  1'b0);  // smallest IA4 image
        run_image(MODE_UNUSED, 16,   8,    96,  1'b1);  // unused mode, spare write
        run_image(MODE_I4,     1024, 1024, 120, 1'b0);  // widest, tallest
        run_image(MODE_IA4,    1024, 4,    100, 1'b0);  // long hold-off lands here
        run_image(MODE_I4,     0,    0,    64,  1'b0);  // both sizes clamp low
        run_image(MODE_IA4,    2047, 2047, 80,  1'b1);  // both sizes clamp high
        run_image(MODE_C4,     13,   5,    128, 1'b0);  // sizes not tile multiples
        run_image(MODE_IA4,    20,   7,    200, 1'b0);
        run_image(MODE_I4,     8,    1024, 200, 1'b0);  // tall narrow, tile rows climb

        // Random settings: mostly small images so image ends come often
        while (words_sent < RANDOM_WORDS) begin
            mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 5))
                0:       w = 8;
                1:       w = 16;
                2:       w = 24;
                3:       w = 32;
                4:       w = $urandom_range(0, 40);
                default: w = $urandom_range(0, 2047);
            endcase
            case ($urandom_range(0, 5))
                0:       h = 4;
                1:       h = 8;
                2:       h = 12;
                3:       h = 16;
                4:       h = $urandom_range(0, 20);
                default: h = $urandom_range(0, 2047);
            endcase
            run_image(mode, w, h, $urandom_range(16, 160), ($urandom_range(0, 3) == 0));
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pairs_pending == 0)
            $display("tiled_nibble_texture_decode_top verification clean");
        else
            $display("tiled_nibble_texture_decode_top verification failed");
        $finish;
    end

endmodule
